### rtl/hrsp_pkg.sv
// Shared types and constants for the HTTP request stream parser.
// No dependencies; imported by hrsp_front, hrsp_back and the top level.
package hrsp_pkg;

   // Result kind codes
   localparam logic [2:0] KIND_METHOD  = 3'd0;
   localparam logic [2:0] KIND_URL     = 3'd1;
   localparam logic [2:0] KIND_VERSION = 3'd2;
   localparam logic [2:0] KIND_KEY     = 3'd3;
   localparam logic [2:0] KIND_VALUE   = 3'd4;
   localparam logic [2:0] KIND_HDONE   = 3'd5;
   localparam logic [2:0] KIND_BODY    = 3'd6;
   localparam logic [2:0] KIND_END_NB  = 3'd7;

   // ASCII codes the parser reacts to
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // "Content-Length" key; hit vector padded to 16 so a 4-bit position indexes it
   localparam int KEY_LEN   = 14;
   localparam int KEY_SLOTS = 16;
   localparam logic [3:0] KEY_LAST = 4'(KEY_LEN);
   localparam logic [7:0] CL_KEY [KEY_LEN] = '{
      8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74,
      8'h2D, 8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68
   };

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   // One classified input beat
   typedef struct packed {
      logic [7:0]           data;
      logic                 sp;
      logic                 colon;
      logic                 cr;
      logic                 lf;
      logic                 ws;
      logic                 digit;
      logic                 plus;
      logic                 minus;
      logic [3:0]           digit_val;
      logic [KEY_SLOTS-1:0] key_hit;
   } class_type;

   typedef enum logic [4:0] {
      PH_METHOD  = 5'b00001,
      PH_URL     = 5'b00010,
      PH_VERSION = 5'b00100,
      PH_HEADER  = 5'b01000,
      PH_BODY    = 5'b10000
   } phase_type;

   typedef enum logic [3:0] {
      HS_KEY      = 4'b0001,
      HS_INTERVAL = 4'b0010,
      HS_VALUE    = 4'b0100,
      HS_END      = 4'b1000
   } hstep_type;

   typedef enum logic [2:0] {
      NS_LEAD   = 3'b001,
      NS_DIGITS = 3'b010,
      NS_DONE   = 3'b100
   } nstep_type;

endpackage

### rtl/hrsp_front.sv
// Front end: accepts request bytes, classifies them and queues them for the back end.
// Depends on hrsp_pkg.
module hrsp_front
   import hrsp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_push,
   output logic      req_full,
   input  logic [7:0] req_in_byte,
   output logic      q_valid,
   output class_type q_item,
   input  logic      q_pop
);

   class_type              mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]     count_ff, count_in;
   logic                   do_push, do_pop;
   class_type              cls;

   always_comb begin
      cls           = '0;
      cls.data      = req_in_byte;
      cls.sp        = (req_in_byte == CH_SPACE);
      cls.colon     = (req_in_byte == CH_COLON);
      cls.cr        = (req_in_byte == CH_CR);
      cls.lf        = (req_in_byte == CH_LF);
      cls.ws        = (req_in_byte == CH_SPACE) || (req_in_byte == CH_TAB) ||
                      (req_in_byte == CH_LF) || (req_in_byte == CH_VT) ||
                      (req_in_byte == CH_FF) || (req_in_byte == CH_CR);
      cls.digit     = (req_in_byte >= CH_ZERO) && (req_in_byte <= CH_NINE);
      cls.plus      = (req_in_byte == CH_PLUS);
      cls.minus     = (req_in_byte == CH_MINUS);
      cls.digit_val = req_in_byte[3:0];
      for (int i = 0; i < KEY_LEN; i++) begin
         cls.key_hit[i] = (req_in_byte == CL_KEY[i]);
      end
   end

   assign req_full = (count_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign q_valid  = (count_ff != '0);
   assign q_item   = mem_ff[rd_ptr_ff];
   assign do_push  = req_push && !req_full;
   assign do_pop   = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

### rtl/hrsp_back.sv
// Back end: request parser state machine, Content-Length conversion and result register.
// Depends on hrsp_pkg; fed from hrsp_front's queue.
module hrsp_back
   import hrsp_pkg::*;
#(
   parameter int LENGTH_BITS = 32
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  class_type   q_item,
   output logic        q_pop,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_request_end,
   output logic [31:0] rsp_body_length
);

   localparam int LB = LENGTH_BITS;

   phase_type         phase_ff, phase_in;
   hstep_type         hstep_ff, hstep_in;
   class_type         held_ff, held_in;
   logic              have_held_ff, have_held_in;
   logic [3:0]        kpos_ff, kpos_in;
   logic              kmatch_ff, kmatch_in;
   logic              len_seen_ff, len_seen_in;
   nstep_type         nstep_ff, nstep_in;
   logic              neg_ff, neg_in;
   logic [LB-1:0]     accum_ff, accum_in;
   logic [LB-1:0]     left_ff, left_in;

   logic              out_valid_ff, out_valid_in;
   logic [2:0]        out_kind_ff, out_kind_in;
   logic [7:0]        out_data_ff, out_data_in;
   logic              out_end_ff, out_end_in;
   logic [31:0]       out_len_ff, out_len_in;

   logic              go;
   logic              emit;
   logic              restart;
   logic              matched;
   logic              feed;
   logic [LB+3:0]     prod;
   logic [LB-1:0]     acc_next;
   logic [LB-1:0]     len_sel;
   class_type         c;
   class_type         a;

   assign c       = q_item;
   assign a       = held_ff;
   assign go      = q_valid && (!out_valid_ff || rsp_pop);
   assign q_pop   = go;
   assign matched = kmatch_ff && (kpos_ff == KEY_LAST);
   assign len_sel = (len_seen_ff && !neg_ff) ? accum_ff : '0;

   // accum*10 + digit, saturating at all ones
   assign prod     = {1'b0, accum_ff, 3'b000} + {3'b000, accum_ff, 1'b0} +
                     (LB+4)'(a.digit_val);
   assign acc_next = (prod[LB+3:LB] != '0) ? '1 : prod[LB-1:0];

   always_comb begin
      phase_in     = phase_ff;
      hstep_in     = hstep_ff;
      held_in      = held_ff;
      have_held_in = have_held_ff;
      kpos_in      = kpos_ff;
      kmatch_in    = kmatch_ff;
      len_seen_in  = len_seen_ff;
      nstep_in     = nstep_ff;
      neg_in       = neg_ff;
      accum_in     = accum_ff;
      left_in      = left_ff;
      emit         = 1'b0;
      restart      = 1'b0;
      feed         = 1'b0;
      out_kind_in  = KIND_METHOD;
      out_data_in  = '0;
      out_end_in   = 1'b0;
      out_len_in   = '0;

      case (phase_ff)
         PH_METHOD, PH_URL: begin
            if (c.sp) begin
               phase_in     = (phase_ff == PH_METHOD) ? PH_URL : PH_VERSION;
               have_held_in = 1'b0;
            end else begin
               emit        = 1'b1;
               out_kind_in = (phase_ff == PH_METHOD) ? KIND_METHOD : KIND_URL;
               out_data_in = c.data;
            end
         end
         PH_VERSION: begin
            if (!have_held_ff) begin
               held_in      = c;
               have_held_in = 1'b1;
            end else if (a.cr && c.lf) begin
               phase_in     = PH_HEADER;
               hstep_in     = HS_KEY;
               have_held_in = 1'b0;
            end else begin
               held_in     = c;
               emit        = 1'b1;
               out_kind_in = KIND_VERSION;
               out_data_in = a.data;
            end
         end
         PH_HEADER: begin
            if (!have_held_ff) begin
               held_in      = c;
               have_held_in = 1'b1;
            end else begin
               held_in = c;
               case (hstep_ff)
                  HS_KEY: begin
                     if (a.colon) begin
                        hstep_in = c.sp ? HS_INTERVAL : HS_VALUE;
                     end else begin
                        if (kmatch_ff && (kpos_ff < KEY_LAST) && a.key_hit[kpos_ff]) begin
                           kpos_in = kpos_ff + 1'b1;
                        end else begin
                           kmatch_in = 1'b0;
                        end
                        emit        = 1'b1;
                        out_kind_in = KIND_KEY;
                        out_data_in = a.data;
                     end
                  end
                  HS_INTERVAL: begin
                     if (!(a.sp && c.sp)) begin
                        hstep_in = HS_VALUE;
                     end
                  end
                  HS_VALUE: begin
                     if (a.cr && c.lf) begin
                        hstep_in = HS_END;
                     end else begin
                        feed        = matched && !len_seen_ff;
                        emit        = 1'b1;
                        out_kind_in = KIND_VALUE;
                        out_data_in = a.data;
                     end
                  end
                  HS_END: begin
                     if (a.lf) begin
                        if (matched) begin
                           len_seen_in = 1'b1;
                        end
                        kpos_in   = '0;
                        kmatch_in = 1'b1;
                        nstep_in  = NS_LEAD;
                        if (!c.cr) begin
                           hstep_in = HS_KEY;
                        end
                        emit        = 1'b1;
                        out_kind_in = KIND_HDONE;
                     end else if (a.cr && c.lf) begin
                        if (len_sel == '0) begin
                           restart     = 1'b1;
                           emit        = 1'b1;
                           out_kind_in = KIND_END_NB;
                           out_end_in  = 1'b1;
                        end else begin
                           accum_in = len_sel;
                           left_in  = len_sel;
                           phase_in = PH_BODY;
                        end
                     end
                  end
                  default: begin
                     hstep_in = HS_KEY;
                  end
               endcase
            end
         end
         PH_BODY: begin
            emit        = 1'b1;
            out_kind_in = KIND_BODY;
            out_data_in = c.data;
            if (left_ff > LB'(1)) begin
               left_in = left_ff - LB'(1);
            end else begin
               restart    = 1'b1;
               out_end_in = 1'b1;
               out_len_in = 32'(accum_ff);
            end
         end
         default: begin
            restart = 1'b1;
         end
      endcase

      // atoi-style conversion of the Content-Length value
      if (feed) begin
         case (nstep_ff)
            NS_LEAD: begin
               if (a.ws) begin
                  nstep_in = NS_LEAD;
               end else if (a.plus) begin
                  nstep_in = NS_DIGITS;
               end else if (a.minus) begin
                  neg_in   = 1'b1;
                  nstep_in = NS_DIGITS;
               end else if (!a.digit) begin
                  nstep_in = NS_DONE;
               end else begin
                  nstep_in = NS_DIGITS;
                  accum_in = acc_next;
               end
            end
            NS_DIGITS: begin
               if (!a.digit) begin
                  nstep_in = NS_DONE;
               end else begin
                  accum_in = acc_next;
               end
            end
            default: begin
               nstep_in = nstep_ff;
            end
         endcase
      end

      // end of request: back to the state after reset
      if (restart) begin
         phase_in     = PH_METHOD;
         hstep_in     = HS_KEY;
         held_in      = '0;
         have_held_in = 1'b0;
         kpos_in      = '0;
         kmatch_in    = 1'b1;
         len_seen_in  = 1'b0;
         nstep_in     = NS_LEAD;
         neg_in       = 1'b0;
         accum_in     = '0;
         left_in      = '0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (go) begin
         out_valid_in = emit;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_METHOD;
         hstep_ff     <= HS_KEY;
         held_ff      <= '0;
         have_held_ff <= 1'b0;
         kpos_ff      <= '0;
         kmatch_ff    <= 1'b1;
         len_seen_ff  <= 1'b0;
         nstep_ff     <= NS_LEAD;
         neg_ff       <= 1'b0;
         accum_ff     <= '0;
         left_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (go) begin
            phase_ff     <= phase_in;
            hstep_ff     <= hstep_in;
            held_ff      <= held_in;
            have_held_ff <= have_held_in;
            kpos_ff      <= kpos_in;
            kmatch_ff    <= kmatch_in;
            len_seen_ff  <= len_seen_in;
            nstep_ff     <= nstep_in;
            neg_ff       <= neg_in;
            accum_ff     <= accum_in;
            left_ff      <= left_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go && emit) begin
         out_kind_ff <= out_kind_in;
         out_data_ff <= out_data_in;
         out_end_ff  <= out_end_in;
         out_len_ff  <= out_len_in;
      end
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_kind        = out_kind_ff;
   assign rsp_data_byte   = out_data_ff;
   assign rsp_request_end = out_end_ff;
   assign rsp_body_length = out_len_ff;

endmodule

### rtl/http_request_stream_parser.sv
// HTTP request stream parser: one request byte per beat, at most one tagged result beat per byte.
// Throughput: one byte per cycle while results are popped; the back end stalls while a result waits.
// Each byte is queued in the front end and its result is registered in the back end; version and
//   header bytes are tagged only once the following byte arrives (one byte of lookahead).
// Reset (synchronous, active high) empties the queue and the result register and returns
//   the parser to the start of a request. Depends on hrsp_pkg, hrsp_front and hrsp_back.
module http_request_stream_parser
   import hrsp_pkg::*;
#(
   parameter int LENGTH_BITS = 32
)
(
   input  logic        clock,
   input  logic        reset,
   // request byte beats
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_in_byte,
   // result beats
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_request_end,
   output logic [31:0] rsp_body_length
);

   // Front: classifies each byte (delimiters, whitespace, digit value, key
   // character hits) and parks it in a short queue. req_full only reflects
   // that queue, so input is accepted while a result waits, until the queue fills.
   logic      q_valid;
   logic      q_pop;
   class_type q_item;

   hrsp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_in_byte (req_in_byte),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop)
   );

   // Back: the request/header state machine, the Content-Length match and
   // its saturating decimal conversion (shift-add times ten), the body byte
   // countdown and the result register. It takes a queued beat whenever the
   // result register is empty or being popped in the same cycle.
   hrsp_back #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_kind        (rsp_kind),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_request_end (rsp_request_end),
      .rsp_body_length (rsp_body_length)
   );

endmodule
